// ----- rtl/core/stq_pkg.sv -----
// Package for the software timer queue: sizing constants, operation and
// result codes, FSM states, sort keys and the control structs passed to the cells.
// No dependencies.
package stq_pkg;

	localparam int NUM_TIMERS = 16;
	// Slot ids are four bits wide, so at most sixteen slots are ever used.
	localparam int SLOT_LIMIT = (NUM_TIMERS < 16) ? NUM_TIMERS : 16;
	localparam int IDX_W      = (SLOT_LIMIT > 1) ? $clog2(SLOT_LIMIT) : 1;
	localparam int CNT_W      = $clog2(SLOT_LIMIT + 1);

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		KIND_START  = 2'd0,
		KIND_CLEAR  = 2'd1,
		KIND_EXPIRY = 2'd2
	} kind_t;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SORT,
		ST_EMIT
	} state_t;

	// Sort key: pending entries (idle = 0) sort first, then by age, then by slot.
	typedef struct packed {
		logic             idle;
		logic [7:0]       age;
		logic [IDX_W-1:0] slot;
	} key_t;

	localparam key_t KEY_NONE = key_t'('1);

	typedef struct packed {
		logic start;
		logic clear;
		logic tick;
		logic emit;
	} cell_ctrl_t;

	typedef struct packed {
		logic load;
		logic step;
		logic shift;
		logic phase;
	} sort_ctrl_t;

endpackage

// ----- rtl/core/software_timer_queue_unit.sv -----
// Start and clear answer in the cycle after the accepting edge; busy stays low.
// A tick loads the sort row, runs odd-even transposition sorting rounds,
// then emits one expiry beat per cycle; busy covers the load, sort and emit
// phases when slots expire, or only the load when none expire.
// The receiver cannot stall. Reset clears all armed flags and the stamp counter.
module software_timer_queue_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [31:0] delay,
	input  logic        periodic,
	input  logic [31:0] target,
	input  logic [31:0] tag,
	input  logic [3:0]  timer_id,
	output logic        result_valid,
	output logic [1:0]  kind,
	output logic [3:0]  slot_id,
	output logic        status,
	output logic [31:0] target_out,
	output logic [31:0] tag_out,
	output logic        last_of_run
);
	import stq_pkg::*;

	state_t state_q, state_d;
	logic [CNT_W-1:0] sort_cnt_q;
	logic [7:0]       stamp_cnt_q;

	logic accept;
	logic do_start, do_clear, do_tick;

	cell_ctrl_t cell_ctrl [SLOT_LIMIT];
	logic [SLOT_LIMIT-1:0] armed_vec;
	logic [SLOT_LIMIT-1:0] expired_vec;
	logic [7:0]  cell_stamp  [SLOT_LIMIT];
	logic [31:0] cell_target [SLOT_LIMIT];
	logic [31:0] cell_tag    [SLOT_LIMIT];

	key_t       load_keys [SLOT_LIMIT];
	key_t       keys_ext  [SLOT_LIMIT+1];
	sort_ctrl_t sort_ctrl;

	logic             free_found;
	logic [IDX_W-1:0] free_idx;
	logic             clear_hit;
	logic [IDX_W-1:0] head_slot;
	logic             head_pending;

	logic        valid_q;
	logic [1:0]  kind_q;
	logic [3:0]  slot_q;
	logic        status_q;
	logic [31:0] target_q;
	logic [31:0] tag_q;
	logic        last_q;

	assign accept   = start && !busy;
	assign do_start = accept && (op == OP_START);
	assign do_clear = accept && (op == OP_CLEAR);
	assign do_tick  = accept && (op == OP_TICK);

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = 0; i < SLOT_LIMIT; i++) begin
			if (!free_found && !armed_vec[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	assign clear_hit = ({1'b0, timer_id} < 5'(SLOT_LIMIT)) && armed_vec[timer_id[IDX_W-1:0]];

	assign head_slot    = keys_ext[0].slot;
	assign head_pending = (state_q == ST_EMIT) && !keys_ext[0].idle;

	always_comb begin
		for (int i = 0; i < SLOT_LIMIT; i++) begin
			cell_ctrl[i].start = do_start && free_found && (free_idx == IDX_W'(i));
			cell_ctrl[i].clear = do_clear && clear_hit
				&& (timer_id[IDX_W-1:0] == IDX_W'(i));
			cell_ctrl[i].tick  = do_tick;
			cell_ctrl[i].emit  = head_pending && (head_slot == IDX_W'(i));
		end
	end

	for (genvar g = 0; g < SLOT_LIMIT; g++) begin : g_slot
		stq_timer_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl[g]),
			.delay      (delay),
			.periodic   (periodic),
			.target     (target),
			.tag        (tag),
			.stamp      (stamp_cnt_q),
			.armed      (armed_vec[g]),
			.expired    (expired_vec[g]),
			.stamp_out  (cell_stamp[g]),
			.target_out (cell_target[g]),
			.tag_out    (cell_tag[g])
		);

		// Age counts back from the newest start, modulo 256.
		assign load_keys[g].idle = !expired_vec[g];
		assign load_keys[g].age  = stamp_cnt_q - 8'd1 - cell_stamp[g];
		assign load_keys[g].slot = IDX_W'(g);

		if (g == 0) begin : g_first
			stq_sort_cell u_sort (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (sort_ctrl),
				.pos_odd   (1'b0),
				.is_first  (1'b1),
				.is_last   (SLOT_LIMIT == 1),
				.load_key  (load_keys[g]),
				.left_key  (KEY_NONE),
				.right_key (keys_ext[g+1]),
				.key       (keys_ext[g])
			);
		end else begin : g_rest
			stq_sort_cell u_sort (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (sort_ctrl),
				.pos_odd   (g % 2 == 1),
				.is_first  (1'b0),
				.is_last   (g == SLOT_LIMIT - 1),
				.load_key  (load_keys[g]),
				.left_key  (keys_ext[g-1]),
				.right_key (keys_ext[g+1]),
				.key       (keys_ext[g])
			);
		end
	end

	assign keys_ext[SLOT_LIMIT] = KEY_NONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		sort_ctrl.load  = 1'b0;
		sort_ctrl.step  = 1'b0;
		sort_ctrl.shift = 1'b0;
		sort_ctrl.phase = sort_cnt_q[0];
		busy            = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start && (op == OP_TICK)) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				sort_ctrl.load = 1'b1;
				state_d = (expired_vec != '0) ? ST_SORT : ST_IDLE;
			end
			ST_SORT: begin
				sort_ctrl.step = 1'b1;
				if (sort_cnt_q == CNT_W'(SLOT_LIMIT - 1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				sort_ctrl.shift = 1'b1;
				if (keys_ext[1].idle) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_cnt_q  <= '0;
			stamp_cnt_q <= 8'd0;
			valid_q     <= 1'b0;
		end else begin
			if (state_q == ST_SORT) begin
				sort_cnt_q <= sort_cnt_q + CNT_W'(1);
			end else begin
				sort_cnt_q <= '0;
			end
			if (do_start && free_found) begin
				stamp_cnt_q <= stamp_cnt_q + 8'd1;
			end
			valid_q <= do_start || do_clear || head_pending;
		end
	end

	always_ff @(posedge clk) begin
		if (do_start) begin
			kind_q   <= KIND_START;
			slot_q   <= free_found ? 4'(free_idx) : 4'd0;
			status_q <= free_found ? STATUS_OK : STATUS_ERR;
			target_q <= 32'd0;
			tag_q    <= 32'd0;
			last_q   <= 1'b1;
		end else if (do_clear) begin
			kind_q   <= KIND_CLEAR;
			slot_q   <= timer_id;
			status_q <= clear_hit ? STATUS_OK : STATUS_ERR;
			target_q <= 32'd0;
			tag_q    <= 32'd0;
			last_q   <= 1'b1;
		end else if (head_pending) begin
			kind_q   <= KIND_EXPIRY;
			slot_q   <= 4'(head_slot);
			status_q <= STATUS_OK;
			target_q <= cell_target[head_slot];
			tag_q    <= cell_tag[head_slot];
			last_q   <= keys_ext[1].idle;
		end
	end

	assign result_valid = valid_q;
	assign kind         = kind_q;
	assign slot_id      = slot_q;
	assign status       = status_q;
	assign target_out   = target_q;
	assign tag_out      = tag_q;
	assign last_of_run  = last_q;

	// Every beat comes from an accepted start or clear or from the emit phase.
	a_beat_source: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($past(state_q) == ST_EMIT)
			|| $past(start && !busy && (op == OP_START || op == OP_CLEAR)))
		else $error("result beat without a source");

	// An expiry is only taken from a slot that is still armed.
	a_emit_armed: assert property (@(posedge clk) disable iff (!arst_n)
		head_pending |-> armed_vec[head_slot])
		else $error("expiry from a free slot");

	// Answers to start and clear are single-beat runs.
	a_answer_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind != KIND_EXPIRY) |-> last_of_run)
		else $error("answer beat not marked last");

	// The sort phase always ends in at least one expiry beat.
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SORT && state_d == ST_EMIT) |=> head_pending)
		else $error("emit phase entered with nothing pending");

endmodule

// ----- rtl/core/stq_timer_cell.sv -----
// One timer slot: armed flag, countdown, reload value, target, tag and stamp.
// Depends on stq_pkg.
module stq_timer_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  stq_pkg::cell_ctrl_t ctrl,
	input  logic [31:0]       delay,
	input  logic              periodic,
	input  logic [31:0]       target,
	input  logic [31:0]       tag,
	input  logic [7:0]        stamp,
	output logic              armed,
	output logic              expired,
	output logic [7:0]        stamp_out,
	output logic [31:0]       target_out,
	output logic [31:0]       tag_out
);
	import stq_pkg::*;

	logic        armed_q;
	logic        expired_q;
	logic [31:0] ticks_q;
	logic [31:0] reload_q;
	logic [31:0] target_q;
	logic [31:0] tag_q;
	logic [7:0]  stamp_q;

	logic at_end;
	assign at_end = (ticks_q <= 32'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q   <= 1'b0;
			expired_q <= 1'b0;
		end else begin
			if (ctrl.start) begin
				armed_q <= 1'b1;
			end else if (ctrl.clear) begin
				armed_q <= 1'b0;
			end else if (ctrl.emit && reload_q == 32'd0) begin
				armed_q <= 1'b0;
			end
			if (ctrl.tick) begin
				expired_q <= armed_q && at_end;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			ticks_q  <= delay;
			reload_q <= periodic ? delay : 32'd0;
			target_q <= target;
			tag_q    <= tag;
			stamp_q  <= stamp;
		end else if (ctrl.tick && armed_q) begin
			// The countdown stops at zero instead of wrapping.
			ticks_q <= at_end ? 32'd0 : ticks_q - 32'd1;
		end else if (ctrl.emit && reload_q != 32'd0) begin
			ticks_q <= reload_q;
		end
	end

	assign armed      = armed_q;
	assign expired    = expired_q;
	assign stamp_out  = stamp_q;
	assign target_out = target_q;
	assign tag_out    = tag_q;

endmodule

// ----- rtl/core/stq_sort_cell.sv -----
// One element of the odd-even transposition sort row that orders expiries.
// Depends on stq_pkg.
module stq_sort_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  stq_pkg::sort_ctrl_t ctrl,
	input  logic                pos_odd,
	input  logic                is_first,
	input  logic                is_last,
	input  stq_pkg::key_t       load_key,
	input  stq_pkg::key_t       left_key,
	input  stq_pkg::key_t       right_key,
	output stq_pkg::key_t       key
);
	import stq_pkg::*;

	key_t key_q;
	logic lower_role;
	logic upper_role;

	// In each round a cell pairs either with its right or its left neighbor.
	assign lower_role = (pos_odd == ctrl.phase) && !is_last;
	assign upper_role = (pos_odd != ctrl.phase) && !is_first;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= KEY_NONE;
		end else if (ctrl.load) begin
			key_q <= load_key;
		end else if (ctrl.shift) begin
			key_q <= right_key;
		end else if (ctrl.step) begin
			if (lower_role && right_key < key_q) begin
				key_q <= right_key;
			end else if (upper_role && left_key > key_q) begin
				key_q <= left_key;
			end
		end
	end

	assign key = key_q;

endmodule
